// ===== rtl/hex_cell_volume_accumulator_defines.svh =====
// Assertion macros for the hexahedral cell volume accumulator.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef HEX_CELL_VOLUME_ACCUMULATOR_DEFINES_SVH
`define HEX_CELL_VOLUME_ACCUMULATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define HCVA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hcva assertion failed");
`define HCVA_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("hcva forbidden condition");
`else
`define HCVA_ASSERT(lbl, prop)
`define HCVA_ASSERT_NEVER(lbl, expr)
`endif
`endif

// ===== rtl/hcva_pkg.sv =====
// Shared types and constants of the hexahedral cell volume accumulator.
// No dependencies.
package hcva_pkg;

  localparam int NodeAw  = 12;
  localparam int CellAw  = 12;
  localparam int CoordW  = 24;
  localparam int NodeW   = 3 * CoordW;
  localparam int VolW    = 64;
  localparam int DivW    = 64;
  localparam int CellCnt = 4096;
  localparam int NodeCnt = 4096;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_FACE = 2'd1,
    KIND_READ = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  localparam logic RES_FACE = 1'b0;
  localparam logic RES_READ = 1'b1;

  localparam logic CFG_MODE   = 1'b0;
  localparam logic CFG_RADIUS = 1'b1;

  typedef struct packed {
    logic              we;
    logic [NodeAw-1:0] addr;
    logic [NodeW-1:0]  wdata;
  } node_req_t;

  typedef struct packed {
    logic [CellAw-1:0] rd_addr;
    logic              we;
    logic [CellAw-1:0] wr_addr;
    logic [VolW-1:0]   wr_data;
  } vol_req_t;

endpackage

// ===== rtl/hcva_node_mem.sv =====
// Single-port node coordinate store with a registered read.
// Depends on hcva_pkg.
module hcva_node_mem (
  input  logic                       clk_i,
  input  hcva_pkg::node_req_t        req_i,
  output logic [hcva_pkg::NodeW-1:0] rdata_o
);

  logic [hcva_pkg::NodeW-1:0] mem_q [hcva_pkg::NodeCnt];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end else begin
      rdata_o <= mem_q[req_i.addr];
    end
  end

endmodule

// ===== rtl/hcva_vol_mem.sv =====
// Cell volume store: one read and one write port, clearing sweep after reset.
// Depends on hcva_pkg.
module hcva_vol_mem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hcva_pkg::vol_req_t        req_i,
  output logic [hcva_pkg::VolW-1:0] rdata_o,
  output logic                      busy_o
);

  logic [hcva_pkg::VolW-1:0] mem_q [hcva_pkg::CellCnt];
  logic [hcva_pkg::CellAw:0] clr_q, clr_d;

  assign busy_o = !clr_q[hcva_pkg::CellAw];
  assign clr_d  = clr_q + (hcva_pkg::CellAw+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (busy_o) begin
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_o) begin
      mem_q[clr_q[hcva_pkg::CellAw-1:0]] <= '0;
    end else if (req_i.we) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    rdata_o <= mem_q[req_i.rd_addr];
  end

endmodule

// ===== rtl/hcva_div3.sv =====
// Serial unsigned divide by three, eight quotient bits per cycle.
// Depends on hcva_pkg.
module hcva_div3 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [hcva_pkg::DivW-1:0] dividend_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [hcva_pkg::DivW-1:0] quot_o
);

  logic [hcva_pkg::DivW-1:0] work_q, work_d;
  logic [1:0]                rem_q, rem_d;
  logic [2:0]                cnt_q;
  logic                      busy_q, done_q;

  always_comb begin
    logic [2:0] r;
    work_d = work_q;
    rem_d  = rem_q;
    for (int j = 0; j < 8; j++) begin
      r = {rem_d, work_d[hcva_pkg::DivW-1]};
      work_d = {work_d[hcva_pkg::DivW-2:0], (r >= 3'd3)};
      rem_d = (r >= 3'd3) ? 2'(r - 3'd3) : r[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 3'd7);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= dividend_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = work_q;

endmodule

// ===== rtl/hex_cell_volume_accumulator.sv =====
// Hexahedral cell volume accumulator: sequencer, shared multiplier, datapath.
// Depends on hcva_pkg, hcva_node_mem, hcva_vol_mem, hcva_div3 and the defines header.
//
// Requests enter on a valid/ready channel, one at a time. A node load is written
// when it is accepted and gives no result. A volume read passes from the store's
// read register through a hold register to the output register. A face reads its
// four corners through the single node memory port, forms the cross product and
// then the dot product and radius on one shared 26x34 multiplier, divides by
// twelve in a serial unit, then updates the left cell and, unless the right cell
// index is negative, the right cell with one read-modify-write pass each.
// Results leave through an output register; a new request is taken while a
// result waits, but the block holds before writing the next result until the
// receiver takes the previous one.
// After reset the volume store is swept to zero, and during the sweep no
// request is taken; configuration writes are taken at any time.
`include "hex_cell_volume_accumulator_defines.svh"
module hex_cell_volume_accumulator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [47:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          kind_i,
  input  logic [11:0]         index_i,
  input  logic signed [23:0]  coord_x_i,
  input  logic signed [23:0]  coord_y_i,
  input  logic signed [23:0]  coord_z_i,
  input  logic [11:0]         corner_a_i,
  input  logic [11:0]         corner_b_i,
  input  logic [11:0]         corner_c_i,
  input  logic [11:0]         corner_d_i,
  input  logic [11:0]         left_cell_i,
  input  logic signed [12:0]  right_cell_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                result_kind_o,
  output logic signed [33:0]  area_x_o,
  output logic signed [33:0]  area_y_o,
  output logic signed [33:0]  area_z_o,
  output logic signed [62:0]  volume_part_o,
  output logic                is_wall_o,
  output logic signed [63:0]  cell_volume_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_NODE  = 4'd1;
  localparam logic [3:0] ST_CROSS = 4'd2;
  localparam logic [3:0] ST_DOT   = 4'd3;
  localparam logic [3:0] ST_DIV   = 4'd4;
  localparam logic [3:0] ST_VL    = 4'd5;
  localparam logic [3:0] ST_VLW   = 4'd6;
  localparam logic [3:0] ST_VR    = 4'd7;
  localparam logic [3:0] ST_VRW   = 4'd8;
  localparam logic [3:0] ST_RDV   = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  localparam logic signed [12:0] RightOpen = -13'sd1;
  localparam logic signed [12:0] RightWall = -13'sd2;
  localparam logic [63:0] DivBias  = 64'h3000_0000_0000_0000;
  localparam logic [62:0] PartBias = 63'h1000_0000_0000_0000;

  logic [3:0]  state_q, state_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        mode_q;
  logic [47:0] rad_q;

  logic [11:0]        corner_q [4];
  logic [11:0]        left_q;
  logic signed [12:0] right_q;

  logic signed [25:0] s_q [3];
  logic signed [24:0] dd_q [3];
  logic signed [24:0] ee_q [3];
  logic signed [59:0] prod_q, acc_q;
  logic signed [50:0] cr_q;
  logic signed [33:0] ar_q [3];
  logic signed [61:0] dot_q;
  logic [52:0]        r2_q;
  logic signed [62:0] part_q;
  logic               wall_q;
  logic [63:0]        rvol_q;

  logic               out_valid_q;
  logic               res_kind_q;
  logic signed [33:0] out_area_q [3];
  logic signed [62:0] out_part_q;
  logic               out_wall_q;
  logic signed [63:0] out_vol_q;

  logic accept, load_out, clr_busy;
  logic [hcva_pkg::NodeW-1:0] node_rdata;
  logic [63:0]                vol_rdata;
  hcva_pkg::node_req_t        node_req;
  hcva_pkg::vol_req_t         vol_req;

  logic signed [25:0] p26 [3];
  logic signed [25:0] op_a;
  logic signed [33:0] op_b;
  logic signed [59:0] mul_p;
  logic signed [51:0] rnd;
  logic signed [62:0] dot_t;
  logic signed [60:0] dot_u;
  logic [63:0]        div_in, div_quot;
  logic               div_start, div_busy, div_done;
  logic [51:0]        r_lim;
  logic               wall_d;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] sum;
    sum = {a[63], a} + {b[63], b};
    if (sum[64] != sum[63]) begin
      return sum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end
    return sum[63:0];
  endfunction

  hcva_node_mem u_node_mem (
    .clk_i   (clk_i),
    .req_i   (node_req),
    .rdata_o (node_rdata)
  );

  hcva_vol_mem u_vol_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (vol_req),
    .rdata_o (vol_rdata),
    .busy_o  (clr_busy)
  );

  hcva_div3 u_div3 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_in),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign in_ready_o = (state_q == ST_IDLE) && !clr_busy;
  assign accept     = in_valid_i && in_ready_o;
  assign load_out   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // node port: write on load, otherwise fetch corners in order
  always_comb begin
    node_req.we    = accept && (kind_i == hcva_pkg::KIND_LOAD);
    node_req.wdata = {coord_z_i, coord_y_i, coord_x_i};
    node_req.addr  = corner_a_i;
    if (state_q == ST_IDLE) begin
      node_req.addr = node_req.we ? index_i : corner_a_i;
    end else if (cnt_q == 3'd0) begin
      node_req.addr = corner_q[1];
    end else if (cnt_q == 3'd1) begin
      node_req.addr = corner_q[2];
    end else begin
      node_req.addr = corner_q[3];
    end
  end

  always_comb begin
    vol_req.rd_addr = left_q;
    vol_req.we      = 1'b0;
    vol_req.wr_addr = left_q;
    vol_req.wr_data = sat_add(vol_rdata, 64'(part_q));
    case (state_q)
      ST_IDLE: vol_req.rd_addr = index_i;
      ST_VR:   vol_req.rd_addr = right_q[11:0];
      ST_VLW:  vol_req.we = 1'b1;
      ST_VRW: begin
        vol_req.we      = 1'b1;
        vol_req.wr_addr = right_q[11:0];
        vol_req.wr_data = sat_add(vol_rdata, -64'(part_q));
      end
      default: vol_req.we = 1'b0;
    endcase
  end

  for (genvar k = 0; k < 3; k++) begin : g_p
    assign p26[k] = 26'(signed'(node_rdata[k*24 +: 24]));
  end

  // shared multiplier operand selection
  always_comb begin
    op_a = 26'(dd_q[0]);
    op_b = 34'(ee_q[1]);
    if (state_q == ST_DOT) begin
      case (cnt_q)
        3'd0:    begin op_a = s_q[0]; op_b = ar_q[0]; end
        3'd1:    begin op_a = s_q[1]; op_b = ar_q[1]; end
        3'd2:    begin op_a = s_q[2]; op_b = ar_q[2]; end
        3'd3:    begin op_a = s_q[0]; op_b = 34'(s_q[0]); end
        default: begin op_a = s_q[1]; op_b = 34'(s_q[1]); end
      endcase
    end else begin
      case (cnt_q)
        3'd0:    begin op_a = 26'(dd_q[2]); op_b = 34'(ee_q[1]); end
        3'd1:    begin op_a = 26'(dd_q[1]); op_b = 34'(ee_q[2]); end
        3'd2:    begin op_a = 26'(dd_q[0]); op_b = 34'(ee_q[2]); end
        3'd3:    begin op_a = 26'(dd_q[2]); op_b = 34'(ee_q[0]); end
        3'd4:    begin op_a = 26'(dd_q[1]); op_b = 34'(ee_q[0]); end
        default: begin op_a = 26'(dd_q[0]); op_b = 34'(ee_q[1]); end
      endcase
    end
  end

  assign mul_p = 60'(op_a) * 60'(op_b);
  assign rnd   = 52'(cr_q) + (cr_q[50] ? 52'sh0FFFF : 52'sh10000);
  assign dot_t = 63'(dot_q) + (dot_q[61] ? 63'sd5 : 63'sd6);
  assign dot_u = dot_t[62:2];
  assign div_in    = 64'(dot_u) + DivBias;
  assign div_start = (state_q == ST_DIV) && (cnt_q == 3'd0);
  assign r_lim     = {rad_q, 4'b0000};
  assign wall_d    = mode_q ? ((right_q == RightOpen) && (r2_q < {1'b0, r_lim}))
                            : (right_q == RightWall);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + 3'd1;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept && kind_i == hcva_pkg::KIND_FACE) begin
          state_d = ST_NODE;
        end else if (accept && kind_i == hcva_pkg::KIND_READ) begin
          state_d = ST_RDV;
        end
      end
      ST_NODE: begin
        if (cnt_q == 3'd3) begin
          state_d = ST_CROSS;
          cnt_d   = '0;
        end
      end
      ST_CROSS: begin
        if (cnt_q == 3'd7) begin
          state_d = ST_DOT;
          cnt_d   = '0;
        end
      end
      ST_DOT: begin
        if (cnt_q == 3'd5) begin
          state_d = ST_DIV;
          cnt_d   = '0;
        end
      end
      ST_DIV: begin
        cnt_d = 3'd1;
        if (div_done) begin
          state_d = ST_VL;
        end
      end
      ST_VL:   state_d = ST_VLW;
      ST_VLW:  state_d = ST_VR;
      ST_VR:   state_d = right_q[12] ? ST_OUT : ST_VRW;
      ST_VRW:  state_d = ST_OUT;
      ST_RDV:  state_d = ST_OUT;
      ST_OUT:  state_d = load_out ? ST_IDLE : ST_OUT;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      mode_q      <= 1'b0;
      rad_q       <= 48'd5196910428;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i && cfg_index_i == hcva_pkg::CFG_MODE) begin
        mode_q <= cfg_data_i[0];
      end
      if (cfg_we_i && cfg_index_i == hcva_pkg::CFG_RADIUS) begin
        rad_q <= cfg_data_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      corner_q[0] <= corner_a_i;
      corner_q[1] <= corner_b_i;
      corner_q[2] <= corner_c_i;
      corner_q[3] <= corner_d_i;
      left_q      <= left_cell_i;
      right_q     <= right_cell_i;
    end
    if (state_q == ST_NODE) begin
      for (int k = 0; k < 3; k++) begin
        case (cnt_q)
          3'd0: begin
            s_q[k]  <= p26[k];
            dd_q[k] <= -25'(p26[k]);
          end
          3'd1: begin
            s_q[k]  <= s_q[k] + p26[k];
            ee_q[k] <= 25'(p26[k]);
          end
          3'd2: begin
            s_q[k]  <= s_q[k] + p26[k];
            dd_q[k] <= dd_q[k] + 25'(p26[k]);
          end
          default: begin
            s_q[k]  <= s_q[k] + p26[k];
            ee_q[k] <= ee_q[k] - 25'(p26[k]);
          end
        endcase
      end
    end
    if (state_q == ST_CROSS || state_q == ST_DOT) begin
      prod_q <= mul_p;
    end
    if (state_q == ST_CROSS) begin
      case (cnt_q)
        3'd1:    acc_q <= prod_q;
        3'd2:    cr_q  <= 51'(acc_q - prod_q);
        3'd3:    begin ar_q[0] <= rnd[50:17]; acc_q <= prod_q; end
        3'd4:    cr_q  <= 51'(acc_q - prod_q);
        3'd5:    begin ar_q[1] <= rnd[50:17]; acc_q <= prod_q; end
        3'd6:    cr_q  <= 51'(acc_q - prod_q);
        3'd7:    ar_q[2] <= rnd[50:17];
        default: acc_q <= acc_q;
      endcase
    end
    if (state_q == ST_DOT) begin
      case (cnt_q)
        3'd1:    dot_q <= 62'(prod_q);
        3'd2:    dot_q <= dot_q + 62'(prod_q);
        3'd3:    dot_q <= dot_q + 62'(prod_q);
        3'd4:    r2_q  <= 53'(prod_q[51:0]);
        3'd5:    r2_q  <= r2_q + 53'(prod_q[51:0]);
        default: r2_q  <= r2_q;
      endcase
    end
    if (state_q == ST_DIV && div_done) begin
      part_q <= signed'(div_quot[62:0] - PartBias);
      wall_q <= wall_d;
    end
    if (state_q == ST_RDV) begin
      rvol_q <= vol_rdata;
    end
    if (load_out) begin
      res_kind_q <= right_q[12] && 1'b0;
      if (cnt_q == 3'd0) begin
        res_kind_q <= 1'b0;
      end
    end
  end

  // read answers come from ST_RDV, face reports from the cross product and divide results
  logic is_read_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_read_q <= 1'b0;
    end else if (accept) begin
      is_read_q <= (kind_i == hcva_pkg::KIND_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      for (int k = 0; k < 3; k++) begin
        out_area_q[k] <= is_read_q ? '0 : ar_q[k];
      end
      out_part_q <= is_read_q ? '0 : part_q;
      out_wall_q <= is_read_q ? 1'b0 : wall_q;
      out_vol_q  <= is_read_q ? signed'(rvol_q) : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = is_read_out_q ? hcva_pkg::RES_READ : hcva_pkg::RES_FACE;
  assign area_x_o      = out_area_q[0];
  assign area_y_o      = out_area_q[1];
  assign area_z_o      = out_area_q[2];
  assign volume_part_o = out_part_q;
  assign is_wall_o     = out_wall_q;
  assign cell_volume_o = out_vol_q;

  logic is_read_out_q;

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      is_read_out_q <= is_read_q;
    end
  end

  `HCVA_ASSERT(a_ready_idle, in_ready_o |-> (state_q == ST_IDLE) && !clr_busy)
  `HCVA_ASSERT(a_face_starts, (accept && kind_i == hcva_pkg::KIND_FACE) |=> state_q == ST_NODE)
  `HCVA_ASSERT_NEVER(a_div_in_div, div_busy && state_q != ST_DIV)
  `HCVA_ASSERT(a_load_sets_valid, load_out |=> out_valid_o)

endmodule

// ===== verif/hcva_volume_checker.sv =====
// Checker for the hexahedral cell volume accumulator: watches the request,
// result and configuration ports, predicts each result and compares it.
// Depends on hcva_pkg for the request kinds and result codes.
module hcva_volume_checker
  import hcva_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [47:0]         cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [1:0]          kind_i,
  input  logic [11:0]         index_i,
  input  logic signed [23:0]  coord_x_i,
  input  logic signed [23:0]  coord_y_i,
  input  logic signed [23:0]  coord_z_i,
  input  logic [11:0]         corner_a_i,
  input  logic [11:0]         corner_b_i,
  input  logic [11:0]         corner_c_i,
  input  logic [11:0]         corner_d_i,
  input  logic [11:0]         left_cell_i,
  input  logic signed [12:0]  right_cell_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic                result_kind_i,
  input  logic signed [33:0]  area_x_i,
  input  logic signed [33:0]  area_y_i,
  input  logic signed [33:0]  area_z_i,
  input  logic signed [62:0]  volume_part_i,
  input  logic                is_wall_i,
  input  logic signed [63:0]  cell_volume_i,
  output int                  pending_o,
  output int                  errors_o
);

  typedef struct {
    logic              kind;
    logic [33:0]       ax;
    logic [33:0]       ay;
    logic [33:0]       az;
    logic [62:0]       part;
    logic              wall;
    logic [63:0]       vol;
  } face_result_t;

  localparam longint VolMax = 64'sh7fff_ffff_ffff_ffff;
  localparam longint VolMin = -64'sh7fff_ffff_ffff_ffff - 1;

  face_result_t      expected_q[$];
  logic              mode_q;
  logic [47:0]       radius_q;
  longint            node_q[NodeCnt][3];
  longint            vol_q[CellCnt];

  assign pending_o = expected_q.size();

  function automatic longint round_div(longint v, longint d);
    longint m;
    longint q;
    m = v < 0 ? -v : v;
    q = (m + d / 2) / d;
    return v < 0 ? -q : q;
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    if (b > 0 && a > VolMax - b) return VolMax;
    if (b < 0 && a < VolMin - b) return VolMin;
    return a + b;
  endfunction

  task automatic predict_face();
    longint p[4][3];
    longint s[3];
    longint dd[3];
    longint ee[3];
    longint cr[3];
    longint ar[3];
    longint dot;
    longint part;
    longint r2;
    logic   wall;
    face_result_t r;
    for (int k = 0; k < 3; k++) begin
      p[0][k] = node_q[corner_a_i][k];
      p[1][k] = node_q[corner_b_i][k];
      p[2][k] = node_q[corner_c_i][k];
      p[3][k] = node_q[corner_d_i][k];
      s[k] = p[0][k] + p[1][k] + p[2][k] + p[3][k];
      dd[k] = p[2][k] - p[0][k];
      ee[k] = p[1][k] - p[3][k];
    end
    cr[0] = dd[2] * ee[1] - dd[1] * ee[2];
    cr[1] = dd[0] * ee[2] - dd[2] * ee[0];
    cr[2] = dd[1] * ee[0] - dd[0] * ee[1];
    for (int k = 0; k < 3; k++) ar[k] = round_div(cr[k], 64'sd131072);
    dot = s[0] * ar[0] + s[1] * ar[1] + s[2] * ar[2];
    part = round_div(dot, 64'sd12);
    vol_q[left_cell_i] = sat_sum(vol_q[left_cell_i], part);
    if (right_cell_i >= 0) vol_q[right_cell_i[11:0]] = sat_sum(vol_q[right_cell_i[11:0]], -part);
    wall = 1'b0;
    if (mode_q == 1'b0) begin
      wall = (right_cell_i == -13'sd2);
    end else if (right_cell_i == -13'sd1) begin
      r2 = s[0] * s[0] + s[1] * s[1];
      wall = r2 < 16 * longint'({16'd0, radius_q});
    end
    r.kind = RES_FACE;
    r.ax = ar[0][33:0];
    r.ay = ar[1][33:0];
    r.az = ar[2][33:0];
    r.part = part[62:0];
    r.wall = wall;
    r.vol = '0;
    expected_q.push_back(r);
  endtask

  task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    face_result_t r;
    if (!rst_ni) begin
      mode_q <= 1'b0;
      radius_q <= 48'd5196910428;
      expected_q.delete();
      errors_o <= 0;
      for (int i = 0; i < CellCnt; i++) vol_q[i] = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_MODE) mode_q <= cfg_data_i[0];
        else radius_q <= cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        case (kind_e'(kind_i))
          KIND_LOAD: begin
            node_q[index_i][0] = coord_x_i;
            node_q[index_i][1] = coord_y_i;
            node_q[index_i][2] = coord_z_i;
          end
          KIND_FACE: predict_face();
          KIND_READ: begin
            r.kind = RES_READ;
            r.ax = '0;
            r.ay = '0;
            r.az = '0;
            r.part = '0;
            r.wall = 1'b0;
            r.vol = vol_q[index_i];
            expected_q.push_back(r);
          end
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with none expected: actual kind %b volume %h", $time,
                   result_kind_i, cell_volume_i);
          errors_o++;
        end else begin
          r = expected_q.pop_front();
          compare_field("result_kind", 64'(r.kind), 64'(result_kind_i));
          compare_field("area_x", 64'(r.ax), 64'(area_x_i[33:0]));
          compare_field("area_y", 64'(r.ay), 64'(area_y_i[33:0]));
          compare_field("area_z", 64'(r.az), 64'(area_z_i[33:0]));
          compare_field("volume_part", 64'(r.part), 64'(volume_part_i[62:0]));
          compare_field("is_wall", 64'(r.wall), 64'(is_wall_i));
          compare_field("cell_volume", r.vol, cell_volume_i);
        end
      end
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the hexahedral cell volume accumulator test: clock, reset, request
// stimulus, result back-pressure, register settings and the verdict.
// Depends on hcva_pkg, the block and hcva_volume_checker.
module testbench;
  import hcva_pkg::*;

  localparam logic signed [23:0] CoordMax = 24'sh7fffff;
  localparam logic signed [23:0] CoordMin = -24'sh800000;
  localparam logic signed [23:0] Big      = 24'sh7fffff;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_index_i;
  logic [47:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         kind_i;
  logic [11:0]        index_i;
  logic signed [23:0] coord_x_i;
  logic signed [23:0] coord_y_i;
  logic signed [23:0] coord_z_i;
  logic [11:0]        corner_a_i;
  logic [11:0]        corner_b_i;
  logic [11:0]        corner_c_i;
  logic [11:0]        corner_d_i;
  logic [11:0]        left_cell_i;
  logic signed [12:0] right_cell_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               result_kind_o;
  logic signed [33:0] area_x_o;
  logic signed [33:0] area_y_o;
  logic signed [33:0] area_z_o;
  logic signed [62:0] volume_part_o;
  logic               is_wall_o;
  logic signed [63:0] cell_volume_o;
  int                 pending;
  int                 errors;

  int                 loaded_q[$];
  bit                 loaded[NodeCnt];
  int                 send_gap_max;
  int                 recv_gap_max;
  bit                 hold_long;

  hex_cell_volume_accumulator u_top (.*);

  hcva_volume_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .kind_i, .index_i,
    .coord_x_i, .coord_y_i, .coord_z_i,
    .corner_a_i, .corner_b_i, .corner_c_i, .corner_d_i,
    .left_cell_i, .right_cell_i,
    .out_valid_i(out_valid_o), .out_ready_i, .result_kind_i(result_kind_o),
    .area_x_i(area_x_o), .area_y_i(area_y_o), .area_z_i(area_z_o),
    .volume_part_i(volume_part_o), .is_wall_i(is_wall_o), .cell_volume_i(cell_volume_o),
    .pending_o(pending), .errors_o(errors)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #6000000;
    $display("** hex_cell_volume_accumulator: FAILED **");
    $finish;
  end

  initial begin
    int n;
    bit v;
    out_ready_i <= 1'b0;
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      n = $urandom_range(0, recv_gap_max);
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        v = out_valid_o;
        @(posedge clk_i);
      end while (!v);
    end
  end

  task automatic offer_request(logic [1:0] kind, logic [11:0] idx,
                               logic signed [23:0] x, logic signed [23:0] y,
                               logic signed [23:0] z, logic [11:0] a, logic [11:0] b,
                               logic [11:0] c, logic [11:0] d, logic [11:0] l,
                               logic signed [12:0] r);
    int gap;
    bit rdy;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    index_i <= idx;
    coord_x_i <= x;
    coord_y_i <= y;
    coord_z_i <= z;
    corner_a_i <= a;
    corner_b_i <= b;
    corner_c_i <= c;
    corner_d_i <= d;
    left_cell_i <= l;
    right_cell_i <= r;
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    if (kind == KIND_LOAD && !loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_q.push_back(idx);
    end
  endtask

  function automatic logic signed [23:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? CoordMax : CoordMin;
      default: return 24'(int'($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  function automatic logic signed [12:0] pick_right();
    case ($urandom_range(0, 3))
      0: return -13'sd1;
      1: return -13'sd2;
      default: return 13'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [11:0] pick_node();
    return loaded_q[$urandom_range(0, loaded_q.size() - 1)];
  endfunction

  task automatic load_node(logic [11:0] idx, logic signed [23:0] x,
                           logic signed [23:0] y, logic signed [23:0] z);
    offer_request(KIND_LOAD, idx, x, y, z, $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom(), $urandom());
  endtask

  task automatic face(logic [11:0] a, logic [11:0] b, logic [11:0] c, logic [11:0] d,
                      logic [11:0] l, logic signed [12:0] r);
    offer_request(KIND_FACE, $urandom(), $urandom(), $urandom(), $urandom(),
                  a, b, c, d, l, r);
  endtask

  task automatic read_cell(logic [11:0] idx);
    offer_request(KIND_READ, idx, $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [47:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: load_node($urandom(), pick_coord(), pick_coord(), pick_coord());
        3: read_cell($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom());
        default: face(pick_node(), pick_node(), pick_node(), pick_node(),
                      $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom(),
                      pick_right());
      endcase
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_MODE;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    kind_i = KIND_LOAD;
    index_i = '0;
    coord_x_i = '0;
    coord_y_i = '0;
    coord_z_i = '0;
    corner_a_i = '0;
    corner_b_i = '0;
    corner_c_i = '0;
    corner_d_i = '0;
    left_cell_i = '0;
    right_cell_i = '0;
    send_gap_max = 8;
    recv_gap_max = 8;
    hold_long = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_node(12'd0, CoordMax, CoordMax, CoordMax);
    load_node(12'd1, CoordMin, CoordMin, CoordMin);
    load_node(12'd4095, CoordMax, CoordMin, CoordMax);
    load_node(12'd2, CoordMin, CoordMax, CoordMin);
    load_node(12'd3, 24'sd65536, 24'sd0, 24'sd0);
    load_node(12'd4, 24'sd0, 24'sd65536, 24'sd0);
    load_node(12'd5, -24'sd65536, 24'sd0, 24'sd65536);
    load_node(12'd6, 24'sd0, -24'sd65536, 24'sd0);
    read_cell(12'd4095);
    face(12'd0, 12'd4095, 12'd1, 12'd2, 12'd4095, 13'sd0);
    face(12'd3, 12'd4, 12'd5, 12'd6, 12'd7, -13'sd2);
    face(12'd3, 12'd4, 12'd5, 12'd6, 12'd7, -13'sd1);
    face(12'd1, 12'd0, 12'd2, 12'd4095, 12'd8, 13'sd8);
    face(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 13'sd4095);
    read_cell(12'd7);
    read_cell(12'd8);
    read_cell(12'd0);
    drain();
    write_reg(CFG_MODE, 48'd1);
    face(12'd3, 12'd4, 12'd5, 12'd6, 12'd9, -13'sd1);
    face(12'd0, 12'd4095, 12'd1, 12'd2, 12'd9, -13'sd1);
    face(12'd3, 12'd4, 12'd5, 12'd6, 12'd9, -13'sd2);
    drain();
    write_reg(CFG_RADIUS, 48'hffff_ffff_ffff);
    face(12'd0, 12'd4095, 12'd1, 12'd2, 12'd9, -13'sd1);
    read_cell(12'd9);
    drain();

    load_node(12'd10, Big, -Big, Big);
    load_node(12'd11, Big, Big, Big);
    load_node(12'd12, -Big, Big, Big);
    load_node(12'd13, -Big, -Big, Big);
    hold_long = 1'b1;
    send_gap_max = 0;
    for (int i = 0; i < 850; i++) begin
      face(12'd10, 12'd11, 12'd12, 12'd13, 12'd20, 13'sd21);
      if (i == 400) begin
        send_gap_max = 8;
        recv_gap_max = 0;
      end
    end
    recv_gap_max = 8;
    read_cell(12'd20);
    read_cell(12'd21);
    drain();

    write_reg(CFG_RADIUS, 48'd0);
    hold_long = 1'b1;
    random_phase(150);
    drain();
    write_reg(CFG_RADIUS, 48'd5196910428 >> $urandom_range(0, 8));
    send_gap_max = 0;
    recv_gap_max = 0;
    random_phase(150);
    drain();
    write_reg(CFG_MODE, 48'd0);
    write_reg(CFG_RADIUS, {$urandom(), $urandom()});
    send_gap_max = 8;
    recv_gap_max = 8;
    random_phase(150);
    drain();
    write_reg(CFG_MODE, 48'd1);
    random_phase(100);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("** hex_cell_volume_accumulator: PASSED **");
    end else begin
      $display("** hex_cell_volume_accumulator: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/hcva_pkg.sv
rtl/hcva_node_mem.sv
rtl/hcva_vol_mem.sv
rtl/hcva_div3.sv
rtl/hex_cell_volume_accumulator.sv
verif/hcva_volume_checker.sv
verif/testbench.sv
